// ===== rtl/swba_pkg.sv =====
`timescale 1ns / 1ps

package swba_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned CW         = $clog2(DEPTH + 1);

  typedef logic [AW-1:0]         addr_t;
  typedef logic [CW-1:0]         cnt_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_PUSH    = 3'd1,
    OP_POP     = 3'd2,
    OP_SWAP_TT = 3'd3,
    OP_REM_BOT = 3'd4,
    OP_SWAP_TB = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SWAP
  } state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic exec;
    logic swap_wr;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic swap_pending;
  } ctl_stat_t;

  // Position off places above base in the ring. base < DEPTH and off <= DEPTH
  // keep the sum below twice the depth, so one subtract wraps it.
  function automatic addr_t ring_add(addr_t base, cnt_t off);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

// ===== rtl/swba_ctrl.sv =====
`timescale 1ns / 1ps

module swba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  swba_pkg::ctl_stat_t stat,
  output swba_pkg::ctl_cmd_t  cmd,
  output logic                busy
);

  swba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      swba_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = swba_pkg::S_READ;
        end
      end
      swba_pkg::S_READ: begin
        cmd.read   = 1'b1;
        state_next = swba_pkg::S_EXEC;
      end
      swba_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.swap_pending) begin
          state_next = swba_pkg::S_SWAP;
        end else begin
          cmd.finish = 1'b1;
          state_next = swba_pkg::S_IDLE;
        end
      end
      swba_pkg::S_SWAP: begin
        cmd.swap_wr = 1'b1;
        cmd.finish  = 1'b1;
        state_next  = swba_pkg::S_IDLE;
      end
      default: begin
        state_next = swba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/swba_dp.sv =====
`timescale 1ns / 1ps

module swba_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  swba_pkg::ctl_cmd_t                  cmd,
  input  logic [2:0]                          operation,
  input  logic [swba_pkg::DATA_WIDTH-1:0]     value,
  output swba_pkg::ctl_stat_t                 stat,
  output logic [1:0]                          status,
  output logic [swba_pkg::DATA_WIDTH-1:0]     data,
  output logic [swba_pkg::CW-1:0]             count,
  output logic                                done
);

  swba_pkg::word_t mem [swba_pkg::DEPTH];

  swba_pkg::op_t   op;
  swba_pkg::word_t val;
  swba_pkg::addr_t bottom, bottom_next;
  swba_pkg::cnt_t  cnt, cnt_next;
  swba_pkg::addr_t addr_a, addr_b;
  swba_pkg::addr_t addr_a_c, addr_b_c;
  swba_pkg::word_t rd_a, rd_b;

  swba_pkg::status_t st_c;
  swba_pkg::word_t   data_c;
  logic              we;
  swba_pkg::addr_t   wa;
  swba_pkg::word_t   wd;
  logic              is_swap;

  swba_pkg::cnt_t cnt_m1, cnt_m2;

  assign cnt_m1 = cnt - swba_pkg::CW'(1);
  assign cnt_m2 = cnt - swba_pkg::CW'(2);

  // Address a is the top (the push slot for a push, the bottom for remove-bottom), address b the second operand.
  always_comb begin
    addr_a_c = swba_pkg::ring_add(bottom, cnt_m1);
    addr_b_c = bottom;
    unique case (op)
      swba_pkg::OP_PUSH:    addr_a_c = swba_pkg::ring_add(bottom, cnt);
      swba_pkg::OP_REM_BOT: addr_a_c = bottom;
      swba_pkg::OP_SWAP_TT: addr_b_c = swba_pkg::ring_add(bottom, cnt_m2);
      default: ;
    endcase
  end

  assign is_swap = (op == swba_pkg::OP_SWAP_TT) || (op == swba_pkg::OP_SWAP_TB);
  assign stat.swap_pending = is_swap && (cnt >= swba_pkg::CW'(2));

  always_comb begin
    st_c        = swba_pkg::ST_OK;
    data_c      = '0;
    cnt_next    = cnt;
    bottom_next = bottom;
    we          = 1'b0;
    wa          = addr_a;
    wd          = rd_b;
    unique case (op)
      swba_pkg::OP_CLEAR: begin
        cnt_next    = '0;
        bottom_next = '0;
      end
      swba_pkg::OP_PUSH: begin
        if (cnt == swba_pkg::CW'(swba_pkg::DEPTH)) begin
          st_c = swba_pkg::ST_FULL;
        end else begin
          we       = 1'b1;
          wd       = val;
          cnt_next = cnt + swba_pkg::CW'(1);
          data_c   = val;
        end
      end
      swba_pkg::OP_POP: begin
        if (cnt == '0) begin
          st_c = swba_pkg::ST_FEW;
        end else begin
          data_c   = rd_a;
          cnt_next = cnt_m1;
        end
      end
      swba_pkg::OP_REM_BOT: begin
        if (cnt == '0) begin
          st_c = swba_pkg::ST_FEW;
        end else begin
          data_c      = rd_a;
          cnt_next    = cnt_m1;
          bottom_next = swba_pkg::ring_add(bottom, swba_pkg::CW'(1));
        end
      end
      swba_pkg::OP_SWAP_TT, swba_pkg::OP_SWAP_TB: begin
        if (cnt < swba_pkg::CW'(2)) begin
          st_c = swba_pkg::ST_FEW;
        end else begin
          we = 1'b1;
        end
      end
      default: ;
    endcase
    // The second half of a swap puts the old top into the lower slot.
    if (cmd.swap_wr) begin
      we = 1'b1;
      wa = addr_b;
      wd = rd_a;
    end else if (!cmd.exec) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= swba_pkg::op_t'(operation);
      val <= value;
    end
    if (cmd.read) begin
      addr_a <= addr_a_c;
      addr_b <= addr_b_c;
      rd_a   <= mem[addr_a_c];
      rd_b   <= mem[addr_b_c];
    end
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.exec) begin
      status <= st_c;
      data   <= data_c;
      count  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      bottom <= '0;
      done   <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.exec) begin
        cnt    <= cnt_next;
        bottom <= bottom_next;
      end
    end
  end

endmodule

// ===== rtl/stack_with_bottom_access_unit.sv =====
`timescale 1ns / 1ps

// Bounded LIFO stack of DEPTH words kept in a ring, with access to both ends.
// An operation is taken when start is high while busy is low; its result
// (status, data, count) is registered and done is high for exactly one cycle, and the
// receiver cannot stall it. A transaction loads the operands, reads in S_READ
// and executes in S_EXEC before done (a successful swap also passes S_SWAP), since
// the single-write-port register file has a registered read and writes one entry at a time; busy
// falls in the cycle done rises, so the next operation may start then.
module stack_with_bottom_access_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      operation,
  input  logic [swba_pkg::DATA_WIDTH-1:0] value,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [swba_pkg::DATA_WIDTH-1:0] data,
  output logic [swba_pkg::CW-1:0]         count
);

  swba_pkg::ctl_cmd_t  cmd;
  swba_pkg::ctl_stat_t stat;

  swba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  swba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (operation),
    .value     (value),
    .stat      (stat),
    .status    (status),
    .data      (data),
    .count     (count),
    .done      (done)
  );

endmodule
